### rtl/pbn_pkg.sv
package pbn_pkg;

  typedef enum logic [1:0] {
    FUNC_ACC  = 2'd0,
    FUNC_FIN  = 2'd1,
    FUNC_NORM = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

endpackage

### rtl/pbn_sqrt.sv
module pbn_sqrt #(
  parameter int CW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2*CW+3:0]     rad_i,
  output logic                done_o,
  output logic [CW+1:0]       root_o
);
  // One result bit a cycle: restoring digit-by-digit square root.
  localparam int RW = 2 * CW + 4;
  localparam int QW = CW + 2;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rad_q, rad_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [QW-1:0]   root_q, root_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   shifted;

  always_comb begin
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_o  = 1'b0;
    shifted = {rem_q[RW-1:0], rad_q[RW-1:RW-2]};
    trial   = (RW+2)'({root_q, 2'b01});
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNTW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign root_o = root_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end
endmodule

### rtl/pbn_div.sv
module pbn_div #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CW-1:0] mag_i,
  input  logic [CW+1:0] den_i,
  output logic          done_o,
  output logic [CW:0]   quo_o
);
  // Restoring divide of mag * 2^FB by den, one bit a cycle, quotient held
  // clamped at 2^(CW-1)+1.
  localparam int NW = CW + FB;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [CW:0] QCLAMP = (CW+1)'(1) << (CW - 1);

  logic [NW-1:0]   num_q, num_d;
  logic [CW+2:0]   rem_q, rem_d;
  logic [CW:0]     quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [CW+2:0]   sh;
  logic [CW+1:0]   qn;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    sh     = {rem_q[CW+1:0], num_q[NW-1]};
    qn     = '0;
    if (start_i) begin
      num_d  = NW'(mag_i) << FB;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (sh >= {1'b0, den_i}) begin
        rem_d = sh - {1'b0, den_i};
        qn    = {quo_q, 1'b1};
      end else begin
        rem_d = sh;
        qn    = {quo_q, 1'b0};
      end
      quo_d = (qn > {1'b0, QCLAMP}) ? QCLAMP + 1'b1 : qn[CW:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end
endmodule

### rtl/point_set_bbox_normalizer_top.sv
// Accumulate words give no result.
// Finalize runs the multiply steps, then the square root (empty result if no point was seen).
// Normalize runs the shared bit-serial divider once per axis (empty result if the scale is
// zero); one word at a time.
// Reset clears the box to empty, the scale to zero and the output to empty.
module point_set_bbox_normalizer_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [COORD_WIDTH-1:0] px_i,
  input  logic [COORD_WIDTH-1:0] py_i,
  input  logic [COORD_WIDTH-1:0] pz_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [COORD_WIDTH-1:0] nx_o,
  output logic [COORD_WIDTH-1:0] ny_o,
  output logic [COORD_WIDTH-1:0] nz_o,
  output logic [COORD_WIDTH+1:0] diag_scale_o,
  output logic [1:0]             status_o
);
  localparam int CW = COORD_WIDTH;
  localparam int SW = CW + 2;
  localparam int RW = 2 * CW + 4;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] bmin_q [3];
  logic [CW-1:0] bmax_q [3];
  logic          seen_q;
  logic [SW-1:0] scale_q;
  logic [1:0]    ax_q;
  logic [CW-1:0] pt_q [3];
  logic [CW-1:0] res_q [3];
  logic          sat_q;
  logic [RW-1:0] acc_q;
  logic          ov_q;
  logic          fin_q;

  logic          acc_in;
  logic [CW:0]   diff;
  logic [2*CW+1:0] sq;
  pbn_pkg::unit_ctl_t sq_ctl, dv_ctl;
  logic          sq_done, dv_done;
  logic [SW-1:0] root;
  logic [CW:0]   quo;
  logic          neg;
  logic [CW-1:0] mag;

  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign acc_in = in_valid_i && !in_stall_o;

  assign diff = {1'b0, bmax_q[ax_q] ^ CMIN} - {1'b0, bmin_q[ax_q] ^ CMIN};
  assign sq = diff * diff;
  assign neg = pt_q[ax_q][CW-1];
  assign mag = neg ? (~pt_q[ax_q] + 1'b1) : pt_q[ax_q];

  assign sq_ctl.start = (state_q == S_MUL) && (ax_q == 2'd2);
  assign sq_ctl.busy  = (state_q == S_SQRT);
  assign dv_ctl.start = (state_q == S_DIV) && !dv_ctl.busy;
  assign dv_ctl.busy  = fin_q;

  pbn_sqrt #(.CW(CW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_ctl.start),
    .rad_i(acc_q + RW'(sq)), .done_o(sq_done), .root_o(root)
  );

  pbn_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(dv_ctl.start), .mag_i(mag),
    .den_i(scale_q), .done_o(dv_done), .quo_o(quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          unique case (pbn_pkg::func_e'(func_i))
            pbn_pkg::FUNC_FIN:  state_d = seen_q ? S_MUL : S_IDLE;
            pbn_pkg::FUNC_NORM: state_d = (scale_q == '0) ? S_IDLE : S_DIV;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_MUL:  if (ax_q == 2'd2) state_d = S_SQRT;
      S_SQRT: if (sq_done) state_d = S_IDLE;
      S_DIV:  if (dv_done && ax_q == 2'd2) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      seen_q  <= 1'b0;
      scale_q <= '0;
      ax_q    <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= CMAX;
        bmax_q[i] <= CMIN;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_o && !out_stall_i) ov_q <= 1'b0;
      fin_q <= dv_ctl.start ? 1'b1 : (dv_done ? 1'b0 : fin_q);
      if (acc_in) begin
        ax_q <= '0;
        unique case (pbn_pkg::func_e'(func_i))
          pbn_pkg::FUNC_ACC: begin
            seen_q <= 1'b1;
            if ($signed(px_i) > $signed(bmax_q[0])) bmax_q[0] <= px_i;
            if ($signed(py_i) > $signed(bmax_q[1])) bmax_q[1] <= py_i;
            if ($signed(pz_i) > $signed(bmax_q[2])) bmax_q[2] <= pz_i;
            if ($signed(px_i) < $signed(bmin_q[0])) bmin_q[0] <= px_i;
            if ($signed(py_i) < $signed(bmin_q[1])) bmin_q[1] <= py_i;
            if ($signed(pz_i) < $signed(bmin_q[2])) bmin_q[2] <= pz_i;
          end
          pbn_pkg::FUNC_FIN: begin
            if (!seen_q) begin
              scale_q <= '0;
              ov_q    <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                bmin_q[i] <= CMAX;
                bmax_q[i] <= CMIN;
              end
            end
          end
          pbn_pkg::FUNC_NORM: if (scale_q == '0) ov_q <= 1'b1;
          default: ;
        endcase
      end
      if (state_q == S_MUL) ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
      if (sq_done) begin
        scale_q <= root;
        seen_q  <= 1'b0;
        ov_q    <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          bmin_q[i] <= CMAX;
          bmax_q[i] <= CMIN;
        end
      end
      if (state_q == S_DIV && dv_done) begin
        ax_q <= ax_q + 1'b1;
        if (ax_q == 2'd2) ov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      pt_q[0] <= px_i;
      pt_q[1] <= py_i;
      pt_q[2] <= pz_i;
      sat_q   <= 1'b0;
      fin_q_dummy_clear: for (int i = 0; i < 3; i++) res_q[i] <= '0;
    end
    if (state_q == S_MUL) acc_q <= (ax_q == 2'd0) ? RW'(sq) : acc_q + RW'(sq);
    if (state_q == S_DIV && dv_done) begin
      if (neg) begin
        if (quo > {1'b0, CMIN}) begin
          res_q[ax_q] <= CMIN;
          sat_q <= 1'b1;
        end else begin
          res_q[ax_q] <= ~quo[CW-1:0] + 1'b1;
        end
      end else if (quo > {1'b0, CMAX}) begin
        res_q[ax_q] <= CMAX;
        sat_q <= 1'b1;
      end else begin
        res_q[ax_q] <= quo[CW-1:0];
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign nx_o         = res_q[0];
  assign ny_o         = res_q[1];
  assign nz_o         = res_q[2];
  assign diag_scale_o = scale_q;
  assign status_o     = (scale_q == '0) ? pbn_pkg::ST_EMPTY :
                        sat_q ? pbn_pkg::ST_SAT : pbn_pkg::ST_OK;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !out_valid_o) else $error("result during divide");
  a_sqrt_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |=> out_valid_o) else $error("finalize result missing");
endmodule

### sim/tb_point_set_bbox_normalizer_top.sv
`timescale 1ns / 1ps

module tb_point_set_bbox_normalizer_top;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CW-1:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [CW-1:0] MAX_NEG = 32'h8000_0000;
  localparam logic [CW-1:0] ONE = 32'h0001_0000;

  typedef struct {
    pbn_pkg::func_e func;
    logic [CW-1:0]  px;
    logic [CW-1:0]  py;
    logic [CW-1:0]  pz;
  } point_word_t;

  typedef struct {
    logic [CW-1:0]    nx;
    logic [CW-1:0]    ny;
    logic [CW-1:0]    nz;
    logic [CW+1:0]    scale;
    pbn_pkg::status_e status;
  } norm_word_t;

  typedef struct {
    point_word_t pw;
    bit          typed;
    norm_word_t  res;
  } table_row_t;

  localparam norm_word_t NO_RES = '{nx: '0, ny: '0, nz: '0, scale: '0,
                                    status: pbn_pkg::ST_OK};

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [1:0]    func_i;
  logic [CW-1:0] px_i;
  logic [CW-1:0] py_i;
  logic [CW-1:0] pz_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [CW-1:0] nx_o;
  logic [CW-1:0] ny_o;
  logic [CW-1:0] nz_o;
  logic [CW+1:0] diag_scale_o;
  logic [1:0]    status_o;

  point_set_bbox_normalizer_top #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (FB)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .px_i        (px_i),
    .py_i        (py_i),
    .pz_i        (pz_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .nx_o        (nx_o),
    .ny_o        (ny_o),
    .nz_o        (nz_o),
    .diag_scale_o(diag_scale_o),
    .status_o    (status_o)
  );

  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];
  logic [CW+1:0]        scale_q;
  bit                   box_used;

  norm_word_t pending_q[$];
  int         err_cnt;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_cycles;
  int         words_sent;
  longint     cycle_cnt;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [CW+1:0] diag_floor();
    logic [CW:0]   d;
    logic [67:0]   sum;
    logic [69:0]   r;
    logic [69:0]   c;
    sum = '0;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      d = {box_hi[a][CW-1], box_hi[a]} - {box_lo[a][CW-1], box_lo[a]};
      sum = sum + 68'(d) * 68'(d);
    end
    for (int b = CW + 2; b >= 0; b--) begin
      c = r | (70'd1 << b);
      if (c * c <= 70'(sum)) begin
        r = c;
      end
    end
    return r[CW+1:0];
  endfunction

  function automatic logic [CW-1:0] divide_coord(logic [CW-1:0] v, ref bit sat);
    logic [CW:0]        mag;
    logic [CW+FB+2:0]   q;
    mag = v[CW-1] ? {1'b0, -v} : {1'b0, v};
    if (v == MAX_NEG) begin
      mag = {1'b1, {CW{1'b0}}} >> 1;
    end
    q = ({(CW+FB+3)'(mag)} << FB) / (CW+FB+3)'(scale_q);
    if (v[CW-1]) begin
      if (q > (CW+FB+3)'(MAX_NEG)) begin
        sat = 1'b1;
        return MAX_NEG;
      end
      return -q[CW-1:0];
    end
    if (q > (CW+FB+3)'(MAX_POS)) begin
      sat = 1'b1;
      return MAX_POS;
    end
    return q[CW-1:0];
  endfunction

  function automatic bit predict_word(point_word_t w, output norm_word_t r);
    bit sat;
    sat = 1'b0;
    r = NO_RES;
    case (w.func)
      pbn_pkg::FUNC_ACC: begin
        if ($signed(w.px) > box_hi[0]) box_hi[0] = w.px;
        if ($signed(w.py) > box_hi[1]) box_hi[1] = w.py;
        if ($signed(w.pz) > box_hi[2]) box_hi[2] = w.pz;
        if ($signed(w.px) < box_lo[0]) box_lo[0] = w.px;
        if ($signed(w.py) < box_lo[1]) box_lo[1] = w.py;
        if ($signed(w.pz) < box_lo[2]) box_lo[2] = w.pz;
        box_used = 1'b1;
        return 1'b0;
      end
      pbn_pkg::FUNC_FIN: begin
        scale_q = box_used ? diag_floor() : '0;
        for (int a = 0; a < 3; a++) begin
          box_lo[a] = MAX_POS;
          box_hi[a] = MAX_NEG;
        end
        box_used = 1'b0;
        r.scale = scale_q;
        r.status = (scale_q == '0) ? pbn_pkg::ST_EMPTY : pbn_pkg::ST_OK;
        return 1'b1;
      end
      pbn_pkg::FUNC_NORM: begin
        if (scale_q == '0) begin
          r.status = pbn_pkg::ST_EMPTY;
          return 1'b1;
        end
        r.nx = divide_coord(w.px, sat);
        r.ny = divide_coord(w.py, sat);
        r.nz = divide_coord(w.pz, sat);
        r.scale = scale_q;
        r.status = sat ? pbn_pkg::ST_SAT : pbn_pkg::ST_OK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(string field, logic [CW+1:0] got, logic [CW+1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
    err_cnt++;
  endtask

  task automatic send_word(point_word_t w, bit typed = 1'b0,
                           norm_word_t typed_res = NO_RES);
    norm_word_t r;
    bit         has_res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= w.func;
    px_i <= w.px;
    py_i <= w.py;
    pz_i <= w.pz;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    has_res = predict_word(w, r);
    if (has_res) begin
      pending_q.push_back(typed ? typed_res : r);
    end
    if (w.func != pbn_pkg::FUNC_NONE) begin
      words_sent++;
    end
  endtask

  always @(posedge clk_i) begin
    norm_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (nx_o !== want.nx) report("nx", (CW+2)'(nx_o), (CW+2)'(want.nx));
        if (ny_o !== want.ny) report("ny", (CW+2)'(ny_o), (CW+2)'(want.ny));
        if (nz_o !== want.nz) report("nz", (CW+2)'(nz_o), (CW+2)'(want.nz));
        if (diag_scale_o !== want.scale) report("diag_scale", diag_scale_o, want.scale);
        if (status_o !== want.status) begin
          report("status", (CW+2)'(status_o), (CW+2)'(want.status));
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_coord(int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return MAX_POS - $urandom_range(0, 3);
      2: return MAX_NEG + $urandom_range(0, 3);
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic point_word_t rand_point(pbn_pkg::func_e f, int span);
    point_word_t w;
    w.func = f;
    w.px = rand_coord(span);
    w.py = rand_coord(span);
    w.pz = rand_coord(span);
    return w;
  endfunction

  initial begin
    table_row_t rows[$];
    point_word_t w;
    int span;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    func_i = pbn_pkg::FUNC_ACC;
    px_i = '0;
    py_i = '0;
    pz_i = '0;
    err_cnt = 0;
    hold_cycles = 0;
    words_sent = 0;
    cycle_cnt = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 70;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = MAX_POS;
      box_hi[a] = MAX_NEG;
    end
    scale_q = '0;
    box_used = 1'b0;

    rows = '{
      '{'{pbn_pkg::FUNC_NORM, MAX_POS, MAX_NEG, ONE}, 1,
        '{0, 0, 0, 0, pbn_pkg::ST_EMPTY}},
      '{'{pbn_pkg::FUNC_FIN, 0, 0, 0}, 1, '{0, 0, 0, 0, pbn_pkg::ST_EMPTY}},
      '{'{pbn_pkg::FUNC_ACC, 0, 0, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_FIN, 0, 0, 0}, 1, '{0, 0, 0, 0, pbn_pkg::ST_EMPTY}},
      '{'{pbn_pkg::FUNC_ACC, MAX_POS, MAX_POS, MAX_POS}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_ACC, MAX_NEG, MAX_NEG, MAX_NEG}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_FIN, MAX_NEG, MAX_POS, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_NORM, MAX_POS, MAX_NEG, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_NORM, 32'hffff_ffff, 1, ONE}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_ACC, 0, 0, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_ACC, ONE, 0, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_FIN, 0, 0, 0}, 1, '{0, 0, 0, 34'(ONE), pbn_pkg::ST_OK}},
      '{'{pbn_pkg::FUNC_NORM, MAX_POS, MAX_NEG, 32'h0001_2345},
        1, '{MAX_POS, MAX_NEG, 32'h0001_2345, 34'(ONE), pbn_pkg::ST_OK}},
      '{'{pbn_pkg::FUNC_NONE, MAX_POS, MAX_POS, MAX_POS}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_ACC, 0, 0, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_ACC, 1, 0, 0}, 0, NO_RES},
      '{'{pbn_pkg::FUNC_FIN, 0, 0, 0}, 1, '{0, 0, 0, 34'd1, pbn_pkg::ST_OK}},
      '{'{pbn_pkg::FUNC_NORM, 1, 32'hffff_ffff, 0}, 1,
        '{ONE, -ONE, 0, 34'd1, pbn_pkg::ST_OK}},
      '{'{pbn_pkg::FUNC_NORM, 32'h0000_8000, 0, 0}, 1,
        '{MAX_POS, 0, 0, 34'd1, pbn_pkg::ST_SAT}},
      '{'{pbn_pkg::FUNC_NORM, 32'hffff_8000, 0, 0}, 1,
        '{MAX_NEG, 0, 0, 34'd1, pbn_pkg::ST_OK}},
      '{'{pbn_pkg::FUNC_NORM, 0, 0, 32'hffff_7fff}, 1,
        '{0, 0, MAX_NEG, 34'd1, pbn_pkg::ST_SAT}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_word(rows[i].pw, rows[i].typed, rows[i].res);
    end

    hold_cycles = 1500;
    while (words_sent < 1370) begin
      if (words_sent > 470) begin
        tx_idle_pct = 70;
        rx_idle_pct = 12;
      end
      if (words_sent > 920) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      span = 1 << $urandom_range(0, 31);
      if ($urandom_range(0, 9) == 0) begin
        w = rand_point(pbn_pkg::func_e'($urandom_range(0, 3)), span);
        send_word(w);
      end else begin
        repeat ($urandom_range(1, 6)) send_word(rand_point(pbn_pkg::FUNC_ACC, span));
        send_word(rand_point(pbn_pkg::FUNC_FIN, span));
        repeat ($urandom_range(1, 5)) send_word(rand_point(pbn_pkg::FUNC_NORM, span));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
